[rtl/atma_pkg.sv]
package atma_pkg;

  localparam int FRAC_BITS    = 16;
  localparam int CORDIC_STEPS = 18;

  localparam int DATA_W = 32;
  localparam int PROD_W = 2 * DATA_W;
  localparam int ACC_W  = PROD_W + 2;

  localparam int ATAN_LEN   = 30;
  localparam int CORDIC_N   = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
  localparam int CORDIC_CW  = 34;
  localparam int ANG_W      = 36;

  localparam longint ANG_FULL    = longint'(360) << FRAC_BITS;
  localparam longint ANG_HALF    = longint'(180) << FRAC_BITS;
  localparam longint ANG_QUARTER = longint'(90) << FRAC_BITS;
  localparam longint ANG_OFS     = ((longint'(1) << 31) + ANG_FULL - 1) / ANG_FULL * ANG_FULL;
  localparam int     ANG_STEPS   = $clog2((longint'(1) << 32) / ANG_FULL + 2);
  localparam int     ANG_CNT_W   = (ANG_STEPS > 1) ? $clog2(ANG_STEPS) : 1;

  localparam logic signed [CORDIC_CW-1:0] CORDIC_GAIN = CORDIC_CW'(652032874);

  localparam logic signed [DATA_W-1:0] FX_ONE = DATA_W'(longint'(1) << FRAC_BITS);

  typedef enum logic [3:0] {
    FN_IDENT  = 4'd0,
    FN_ROTX   = 4'd1,
    FN_ROTY   = 4'd2,
    FN_ROTZ   = 4'd3,
    FN_SCALE  = 4'd4,
    FN_TRANS  = 4'd5,
    FN_STAGE  = 4'd6,
    FN_MULT   = 4'd7,
    FN_READ   = 4'd8
  } func_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CORDIC,
    ST_MUL,
    ST_ACC,
    ST_RND,
    ST_WRROW,
    ST_OUT
  } state_e;

  typedef enum logic [2:0] {
    CS_IDLE,
    CS_RED,
    CS_FOLD,
    CS_ITER,
    CS_FIN
  } cordic_state_e;

  function automatic logic signed [CORDIC_CW-1:0] atan_deg(input logic [4:0] idx);
    logic signed [CORDIC_CW-1:0] v;
    case (idx)
      5'd0:  v = CORDIC_CW'(754974720);
      5'd1:  v = CORDIC_CW'(445687602);
      5'd2:  v = CORDIC_CW'(235489088);
      5'd3:  v = CORDIC_CW'(119537938);
      5'd4:  v = CORDIC_CW'(60000934);
      5'd5:  v = CORDIC_CW'(30029717);
      5'd6:  v = CORDIC_CW'(15018523);
      5'd7:  v = CORDIC_CW'(7509720);
      5'd8:  v = CORDIC_CW'(3754917);
      5'd9:  v = CORDIC_CW'(1877466);
      5'd10: v = CORDIC_CW'(938734);
      5'd11: v = CORDIC_CW'(469367);
      5'd12: v = CORDIC_CW'(234684);
      5'd13: v = CORDIC_CW'(117342);
      5'd14: v = CORDIC_CW'(58671);
      5'd15: v = CORDIC_CW'(29335);
      5'd16: v = CORDIC_CW'(14668);
      5'd17: v = CORDIC_CW'(7334);
      5'd18: v = CORDIC_CW'(3667);
      5'd19: v = CORDIC_CW'(1833);
      5'd20: v = CORDIC_CW'(917);
      5'd21: v = CORDIC_CW'(458);
      5'd22: v = CORDIC_CW'(229);
      5'd23: v = CORDIC_CW'(115);
      5'd24: v = CORDIC_CW'(57);
      5'd25: v = CORDIC_CW'(29);
      5'd26: v = CORDIC_CW'(14);
      5'd27: v = CORDIC_CW'(7);
      5'd28: v = CORDIC_CW'(4);
      5'd29: v = CORDIC_CW'(2);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

[rtl/atma_cordic.sv]
module atma_cordic
  import atma_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic signed [DATA_W-1:0] angle_i,
  output logic                     done_o,
  output logic signed [DATA_W-1:0] cos_o,
  output logic signed [DATA_W-1:0] sin_o
);

  cordic_state_e state_q, state_d;

  logic signed [ANG_W-1:0]     ang_q;
  logic [ANG_CNT_W-1:0]        n_q;
  logic signed [CORDIC_CW-1:0] x_q, y_q, z_q;
  logic [4:0]                  it_q;
  logic                        neg_q;
  logic                        done_q;
  logic signed [DATA_W-1:0]    cos_q, sin_q;

  logic signed [ANG_W-1:0]     full_sh;
  logic signed [ANG_W-1:0]     wrap;
  logic signed [ANG_W-1:0]     fold;
  logic                        fold_neg;
  logic signed [CORDIC_CW-1:0] xs, ys;
  logic signed [CORDIC_CW-1:0] rc, rs;

  assign full_sh = ANG_W'(ANG_FULL) <<< n_q;

  always_comb begin
    wrap = (ang_q >= ANG_W'(ANG_HALF)) ? ang_q - ANG_W'(ANG_FULL) : ang_q;
    fold = wrap;
    fold_neg = 1'b0;
    if (wrap > ANG_W'(ANG_QUARTER)) begin
      fold = wrap - ANG_W'(ANG_HALF);
      fold_neg = 1'b1;
    end else if (wrap < -ANG_W'(ANG_QUARTER)) begin
      fold = wrap + ANG_W'(ANG_HALF);
      fold_neg = 1'b1;
    end
  end

  assign xs = x_q >>> it_q;
  assign ys = y_q >>> it_q;
  assign rc = (x_q + CORDIC_CW'(longint'(1) << (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
  assign rs = (y_q + CORDIC_CW'(longint'(1) << (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);

  always_comb begin
    state_d = state_q;
    case (state_q)
      CS_IDLE: if (start_i) state_d = CS_RED;
      CS_RED:  if (n_q == '0) state_d = CS_FOLD;
      CS_FOLD: state_d = CS_ITER;
      CS_ITER: if (it_q == 5'(CORDIC_N - 1)) state_d = CS_FIN;
      CS_FIN:  state_d = CS_IDLE;
      default: state_d = CS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == CS_FIN);
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      CS_IDLE: begin
        if (angle_i < 0) begin
          ang_q <= ANG_W'(angle_i) + ANG_W'(ANG_OFS);
        end else begin
          ang_q <= ANG_W'(angle_i);
        end
        n_q <= ANG_CNT_W'(ANG_STEPS - 1);
      end
      CS_RED: begin
        if (ang_q >= full_sh) ang_q <= ang_q - full_sh;
        if (n_q != '0) n_q <= n_q - 1'b1;
      end
      CS_FOLD: begin
        z_q   <= CORDIC_CW'(fold <<< (24 - FRAC_BITS));
        x_q   <= CORDIC_GAIN;
        y_q   <= '0;
        it_q  <= '0;
        neg_q <= fold_neg;
      end
      CS_ITER: begin
        if (z_q >= 0) begin
          x_q <= x_q - ys;
          y_q <= y_q + xs;
          z_q <= z_q - atan_deg(it_q);
        end else begin
          x_q <= x_q + ys;
          y_q <= y_q - xs;
          z_q <= z_q + atan_deg(it_q);
        end
        it_q <= it_q + 1'b1;
      end
      CS_FIN: begin
        cos_q <= neg_q ? -DATA_W'(rc) : DATA_W'(rc);
        sin_q <= neg_q ? -DATA_W'(rs) : DATA_W'(rs);
      end
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign cos_o  = cos_q;
  assign sin_o  = sin_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> $past(state_q == CS_FIN))
    else $error("cordic done without a finishing step");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (state_q == CS_RED && n_q == '0) |=> state_q == CS_FOLD)
    else $error("angle reduction did not end");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (state_q == CS_ITER) |-> it_q < 5'(CORDIC_N))
    else $error("cordic step count overran");

endmodule

[rtl/affine_transform_matrix_accumulator_top.sv]
// Identity and staging are taken in the idle state; a matrix product works through
// 16 entries (4 multiply and add pairs plus one rounding step each), then 4 row writes.
// Rotations first run the angle unit for the cosine and sine.
// A read delivers four row transfers, one per cycle when the sink does not stall.
// Throughput is one item at a time on a single shared 32x32 multiplier.
// Reset is asynchronous and active low; the matrix returns to identity.
module affine_transform_matrix_accumulator_top
  import atma_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [3:0]               func_i,
  input  logic [1:0]               row_sel_i,
  input  logic signed [DATA_W-1:0] val_x_i,
  input  logic signed [DATA_W-1:0] val_y_i,
  input  logic signed [DATA_W-1:0] val_z_i,
  input  logic signed [DATA_W-1:0] val_w_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [1:0]               row_index_o,
  output logic signed [DATA_W-1:0] col0_o,
  output logic signed [DATA_W-1:0] col1_o,
  output logic signed [DATA_W-1:0] col2_o,
  output logic signed [DATA_W-1:0] col3_o,
  output logic                     saturated_o,
  output logic                     last_o
);

  state_e state_q, state_d;

  logic signed [DATA_W-1:0] mat_q [4][4];
  logic signed [DATA_W-1:0] stg_q [3][4];
  logic signed [DATA_W-1:0] rowbuf_q [4];
  logic [3:0]               func_q;
  logic signed [DATA_W-1:0] vx_q, vy_q, vz_q;
  logic [1:0]               i_q, j_q, k_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic                     sat_q;

  logic                     in_xfer, out_xfer;
  logic                     cs_start, cs_done;
  logic signed [DATA_W-1:0] cs_cos, cs_sin, cs_angle;
  logic signed [DATA_W-1:0] a_elem, m_elem;
  logic signed [ACC_W-1:0]  rnd;
  logic                     rnd_hi, rnd_lo;

  assign in_xfer  = in_valid_i && !in_stall_o;
  assign out_xfer = out_valid_o && !out_stall_i;
  assign cs_start = in_xfer && (func_i == FN_ROTX || func_i == FN_ROTY || func_i == FN_ROTZ);

  always_comb begin
    case (func_i)
      FN_ROTX: cs_angle = val_x_i;
      FN_ROTY: cs_angle = val_y_i;
      default: cs_angle = val_z_i;
    endcase
  end

  atma_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cs_start),
    .angle_i (cs_angle),
    .done_o  (cs_done),
    .cos_o   (cs_cos),
    .sin_o   (cs_sin)
  );

  assign a_elem = mat_q[i_q][k_q];

  always_comb begin
    m_elem = (k_q == j_q) ? FX_ONE : '0;
    case (func_q)
      FN_ROTX: begin
        if ((k_q == 2'd1 && j_q == 2'd1) || (k_q == 2'd2 && j_q == 2'd2)) m_elem = cs_cos;
        if (k_q == 2'd2 && j_q == 2'd1) m_elem = cs_sin;
        if (k_q == 2'd1 && j_q == 2'd2) m_elem = -cs_sin;
      end
      FN_ROTY: begin
        if ((k_q == 2'd0 && j_q == 2'd0) || (k_q == 2'd2 && j_q == 2'd2)) m_elem = cs_cos;
        if (k_q == 2'd2 && j_q == 2'd0) m_elem = -cs_sin;
        if (k_q == 2'd0 && j_q == 2'd2) m_elem = cs_sin;
      end
      FN_ROTZ: begin
        if ((k_q == 2'd0 && j_q == 2'd0) || (k_q == 2'd1 && j_q == 2'd1)) m_elem = cs_cos;
        if (k_q == 2'd1 && j_q == 2'd0) m_elem = cs_sin;
        if (k_q == 2'd0 && j_q == 2'd1) m_elem = -cs_sin;
      end
      FN_SCALE: begin
        if (k_q == 2'd0 && j_q == 2'd0) m_elem = vx_q;
        if (k_q == 2'd1 && j_q == 2'd1) m_elem = vy_q;
        if (k_q == 2'd2 && j_q == 2'd2) m_elem = vz_q;
      end
      FN_TRANS: begin
        if (k_q == 2'd0 && j_q == 2'd3) m_elem = vx_q;
        if (k_q == 2'd1 && j_q == 2'd3) m_elem = vy_q;
        if (k_q == 2'd2 && j_q == 2'd3) m_elem = vz_q;
      end
      FN_MULT: begin
        if (k_q != 2'd3) m_elem = stg_q[k_q][j_q];
      end
      default: ;
    endcase
  end

  assign rnd    = (acc_q + ACC_W'(longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
  assign rnd_hi = rnd > ACC_W'(32'sh7fff_ffff);
  assign rnd_lo = rnd < -(ACC_W'(1) <<< (DATA_W - 1));

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          case (func_i)
            FN_ROTX, FN_ROTY, FN_ROTZ: state_d = ST_CORDIC;
            FN_SCALE, FN_TRANS, FN_MULT: state_d = ST_MUL;
            FN_READ: state_d = ST_OUT;
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_CORDIC: if (cs_done) state_d = ST_MUL;
      ST_MUL:    state_d = ST_ACC;
      ST_ACC:    state_d = (k_q == 2'd3) ? ST_RND : ST_MUL;
      ST_RND:    state_d = (j_q == 2'd3) ? ST_WRROW : ST_MUL;
      ST_WRROW:  state_d = (i_q == 2'd3) ? ST_IDLE : ST_MUL;
      ST_OUT:    if (out_xfer && i_q == 2'd3) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      sat_q   <= 1'b0;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 4; c++) begin
          mat_q[r][c] <= (r == c) ? FX_ONE : '0;
        end
      end
    end else begin
      state_q <= state_d;
      case (state_q)
        ST_IDLE: begin
          i_q <= '0;
          j_q <= '0;
          k_q <= '0;
          if (in_xfer && func_i == FN_IDENT) begin
            for (int r = 0; r < 4; r++) begin
              for (int c = 0; c < 4; c++) begin
                mat_q[r][c] <= (r == c) ? FX_ONE : '0;
              end
            end
          end
        end
        ST_ACC: k_q <= k_q + 1'b1;
        ST_RND: begin
          if (rnd_hi || rnd_lo) sat_q <= 1'b1;
          j_q <= j_q + 1'b1;
        end
        ST_WRROW: begin
          for (int c = 0; c < 4; c++) mat_q[i_q][c] <= rowbuf_q[c];
          i_q <= i_q + 1'b1;
        end
        ST_OUT: begin
          if (out_xfer) begin
            i_q <= i_q + 1'b1;
            if (i_q == 2'd3) sat_q <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      func_q <= func_i;
      vx_q   <= val_x_i;
      vy_q   <= val_y_i;
      vz_q   <= val_z_i;
      if (func_i == FN_STAGE && row_sel_i != 2'd3) begin
        stg_q[row_sel_i[1:0]][0] <= val_x_i;
        stg_q[row_sel_i[1:0]][1] <= val_y_i;
        stg_q[row_sel_i[1:0]][2] <= val_z_i;
        stg_q[row_sel_i[1:0]][3] <= val_w_i;
      end
    end
    if (state_q == ST_MUL) prod_q <= a_elem * m_elem;
    if (state_q == ST_ACC) begin
      acc_q <= (k_q == 2'd0) ? ACC_W'(prod_q) : acc_q + ACC_W'(prod_q);
    end
    if (state_q == ST_RND) begin
      if (rnd_hi) begin
        rowbuf_q[j_q] <= 32'sh7fff_ffff;
      end else if (rnd_lo) begin
        rowbuf_q[j_q] <= 32'sh8000_0000;
      end else begin
        rowbuf_q[j_q] <= rnd[DATA_W-1:0];
      end
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);
  assign row_index_o = i_q;
  assign col0_o      = mat_q[i_q][0];
  assign col1_o      = mat_q[i_q][1];
  assign col2_o      = mat_q[i_q][2];
  assign col3_o      = mat_q[i_q][3];
  assign saturated_o = sat_q;
  assign last_o      = (i_q == 2'd3);

  assert property (@(posedge clk_i) disable iff (!rst_ni) out_valid_o |-> in_stall_o)
    else $error("input taken during a readout");
  assert property (@(posedge clk_i) disable iff (!rst_ni) (out_xfer && last_o) |=> !sat_q)
    else $error("saturation flag not cleared after a readout");
  assert property (@(posedge clk_i) disable iff (!rst_ni) cs_done |-> state_q == ST_CORDIC)
    else $error("angle result arrived outside a rotation");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (state_q == ST_WRROW && i_q == 2'd3) |=> state_q == ST_IDLE)
    else $error("product did not end after the last row");

endmodule
